// File: hw/rtl/plpc_pkg.sv
// Shared types and constants of the per-line pattern counter.
package plpc_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned PATTERN_W = 64;
   localparam int unsigned PLEN_W = 4;
   localparam int unsigned LANE_IDX_W = 3;
   localparam int unsigned LINE_W = 20;
   localparam int unsigned COUNT_W = 12;
   localparam int unsigned CSR_ADDR_W = 4;

   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;
   localparam logic [LINE_W-1:0] LINE_MAX = 20'd1048575;

   // Register select: address bit 3 picks the register (8-byte spacing).
   typedef enum logic {
      REG_PATTERN_BYTES  = 1'b0,
      REG_PATTERN_LENGTH = 1'b1
   } csr_reg_type;

   // Control broadcast to every window cell.
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   // Data handed from one cell to the next older one.
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              valid;
   } cell_link_type;

   // Per-request control into the counting stage.
   typedef struct packed {
      logic accept;
      logic newline;
      logic hit;
   } tally_ctrl_type;

endpackage

// File: hw/rtl/plpc_cell.sv
// One window cell: holds one recent text byte and compares the byte it takes on a shift to its pattern byte.
module plpc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  plpc_pkg::cell_ctrl_type ctrl,
   input  plpc_pkg::cell_link_type link_in,
   output plpc_pkg::cell_link_type link_out,
   input  logic [7:0]              pat_byte,
   input  logic                    in_use,
   output logic                    hit
);
   import plpc_pkg::*;

   logic [BYTE_W-1:0] data_ff;
   logic [BYTE_W-1:0] data_in;
   logic              valid_ff;
   logic              valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         data_in  = link_in.data;
         valid_in = link_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Compare against the byte this cell takes on the shift.
   assign hit = !in_use || (link_in.valid && (link_in.data == pat_byte));

   assign link_out.data  = data_ff;
   assign link_out.valid = valid_ff;

endmodule

// File: hw/rtl/plpc_tally.sv
// Match counter, line counter and result output register.
module plpc_tally (
   input  logic                              clock,
   input  logic                              reset,
   input  plpc_pkg::tally_ctrl_type          ctrl,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [plpc_pkg::LINE_W-1:0]       rsp_line_index,
   output logic [plpc_pkg::COUNT_W-1:0]      rsp_match_count
);
   import plpc_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [LINE_W-1:0]  line_ff;
   logic [LINE_W-1:0]  line_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [LINE_W-1:0]  rsp_line_ff;
   logic [LINE_W-1:0]  rsp_line_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [COUNT_W-1:0] rsp_count_in;
   logic               emit;

   assign emit = ctrl.accept && ctrl.newline && (count_ff != '0);

   always_comb begin
      count_in     = count_ff;
      line_in      = line_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_line_in  = rsp_line_ff;
      rsp_count_in = rsp_count_ff;
      if (ctrl.accept) begin
         if (ctrl.newline) begin
            count_in = '0;
            if (line_ff != LINE_MAX) begin
               line_in = line_ff + 1'b1;
            end
         end else if (ctrl.hit && (count_ff != COUNT_MAX)) begin
            count_in = count_ff + 1'b1;
         end
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_line_in  = line_ff;
         rsp_count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         line_ff      <= LINE_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         line_ff      <= line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_line_ff  <= rsp_line_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_line_index  = rsp_line_ff;
   assign rsp_match_count = rsp_count_ff;

endmodule

// File: hw/rtl/per_line_pattern_count.sv
// Top level of the per-line pattern counter: CSRs, window cell chain, counting stage.
// Throughput: one text byte per cycle, sustained, while the result side keeps up.
// A line with at least one match shows its result on rsp_valid in the cycle after its newline is accepted.
// The single-cycle rate comes from the cell chain: all cells compare in parallel and
// the window shifts by one cell on each accepted request that is not a newline.
// Reset (synchronous, active high): empty window, count 0, line 1, no pending result,
// pattern_bytes 0 and pattern_length 1.
module per_line_pattern_count #(
   parameter int unsigned MAX_PATTERN = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // text request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [plpc_pkg::BYTE_W-1:0]          req_text_byte,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [plpc_pkg::LINE_W-1:0]          rsp_line_index,
   output logic [plpc_pkg::COUNT_W-1:0]         rsp_match_count,
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [plpc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [plpc_pkg::PATTERN_W-1:0]       csr_pwdata,
   output logic [plpc_pkg::PATTERN_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import plpc_pkg::*;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [PATTERN_W-1:0] pattern_ff;
   logic [PATTERN_W-1:0] pattern_in;
   logic [PLEN_W-1:0]    plen_ff;
   logic [PLEN_W-1:0]    plen_in;
   logic                 csr_write;
   csr_reg_type          csr_sel;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // Bit 3 picks the register; lower address bits are ignored.
   assign csr_sel    = csr_reg_type'(csr_paddr[3]);

   always_comb begin
      pattern_in = pattern_ff;
      plen_in    = plen_ff;
      if (csr_write) begin
         unique case (csr_sel)
            REG_PATTERN_BYTES:  pattern_in = csr_pwdata;
            REG_PATTERN_LENGTH: plen_in    = csr_pwdata[PLEN_W-1:0];
            default:            pattern_in = pattern_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         plen_ff    <= PLEN_W'(1);
      end else begin
         pattern_ff <= pattern_in;
         plen_ff    <= plen_in;
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_PATTERN_BYTES:  csr_prdata = pattern_ff;
         REG_PATTERN_LENGTH: csr_prdata = {{(PATTERN_W-PLEN_W){1'b0}}, plen_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // Length in use: zero acts as one, anything past the window acts as the window size.
   logic [PLEN_W-1:0] len_use;

   always_comb begin
      priority if (plen_ff == '0) begin
         len_use = PLEN_W'(1);
      end else if (plen_ff > PLEN_W'(MAX_PATTERN)) begin
         len_use = PLEN_W'(MAX_PATTERN);
      end else begin
         len_use = plen_ff;
      end
   end

   // ------------------------------------------------------------------
   // Request handshake
   // ------------------------------------------------------------------
   // Take a request whenever the result register is empty or being drained.
   logic accept;
   logic is_newline;

   assign req_ready  = !rsp_valid || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign is_newline = (req_text_byte == NEWLINE_BYTE);

   // ------------------------------------------------------------------
   // Window cell chain: cell 0 holds the newest byte, higher cells older ones.
   // A newline clears every cell; any other byte shifts the chain by one.
   // ------------------------------------------------------------------
   cell_ctrl_type cell_ctrl;
   cell_link_type link [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0] cell_hit;

   assign cell_ctrl.shift = accept && !is_newline;
   assign cell_ctrl.clear = accept && is_newline;

   assign link[0].data  = req_text_byte;
   assign link[0].valid = 1'b1;

   for (genvar a = 0; a < MAX_PATTERN; a++) begin : g_cell
      logic [PLEN_W-1:0] lane;
      logic              in_use;
      logic [7:0]        pat_byte;

      // The cell at age a faces pattern byte len-1-a when a lies inside the pattern.
      assign in_use   = (PLEN_W'(a) < len_use);
      assign lane     = len_use - PLEN_W'(a) - PLEN_W'(1);
      assign pat_byte = pattern_ff[lane[LANE_IDX_W-1:0]*BYTE_W +: BYTE_W];

      plpc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .link_in  (link[a]),
         .link_out (link[a+1]),
         .pat_byte (pat_byte),
         .in_use   (in_use),
         .hit      (cell_hit[a])
      );
   end

   // The last cell's output has no neighbor; the chain simply ends there.
   cell_link_type chain_end;
   assign chain_end = link[MAX_PATTERN];

   // ------------------------------------------------------------------
   // Counting stage and result register
   // ------------------------------------------------------------------
   tally_ctrl_type tally_ctrl;

   // A match needs every in-use cell to agree; the unused tail of the chain reports hit.
   assign tally_ctrl.accept  = accept;
   assign tally_ctrl.newline = is_newline;
   assign tally_ctrl.hit     = (&cell_hit) && (chain_end.valid || !chain_end.valid);

   plpc_tally u_tally (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (tally_ctrl),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_line_index  (rsp_line_index),
      .rsp_match_count (rsp_match_count)
   );

endmodule

// File: hw/rtl/plpc_checker.sv
// Port-level assertions for the per-line pattern counter, bound to the top level.
module plpc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [plpc_pkg::BYTE_W-1:0]          req_text_byte,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [plpc_pkg::LINE_W-1:0]          rsp_line_index,
   input logic [plpc_pkg::COUNT_W-1:0]         rsp_match_count,
   input logic                                 csr_pready
);
   import plpc_pkg::*;

   // A result appears only in the cycle after a newline request is taken.
   a_rsp_after_newline: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_text_byte == NEWLINE_BYTE)))
      else $error("result raised without an accepted newline");

   // A reported line always carries at least one match and a line number of one or more.
   a_rsp_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_match_count != '0) && (rsp_line_index != '0))
      else $error("result with zero count or zero line number");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_line_index) && $stable(rsp_match_count))
      else $error("stalled result changed");

   // Reset leaves no result pending.
   a_reset_clears: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result pending after reset");

   // The register port never stalls.
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready dropped");

endmodule

bind per_line_pattern_count plpc_checker u_plpc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_text_byte   (req_text_byte),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_line_index  (rsp_line_index),
   .rsp_match_count (rsp_match_count),
   .csr_pready      (csr_pready)
);
